[hdl/dcqa_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// dcqa_pkg
// Shared types and constants of the dual-channel qualified averager: register
// indices, fixed field widths, controller states and the command and status
// groups between controller and datapath.
// ============================================================================
package dcqa_pkg;

    // Fixed field widths
    localparam int WIN_W     = 11;
    localparam int LIMIT_W   = 12;
    localparam int FLIM_W    = 8;
    localparam int CODE_W    = 16;
    localparam int VALUE_W   = 16;
    localparam int CFG_IDX_W = 3;

    // Configuration register indices
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_LOW     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_HIGH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FAULT_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FAULT_CODE    = 3'd4;

    // Configuration reset values
    localparam logic [WIN_W-1:0]   RST_WINDOW_LENGTH = 11'd16;
    localparam logic [LIMIT_W-1:0] RST_VALID_LOW     = 12'd0;
    localparam logic [LIMIT_W-1:0] RST_VALID_HIGH    = 12'd4095;
    localparam logic [FLIM_W-1:0]  RST_FAULT_LIMIT   = 8'd3;
    localparam logic [CODE_W-1:0]  RST_FAULT_CODE    = 16'hFFFF;

    // Channel codes
    localparam logic CH_TEMP  = 1'b0;
    localparam logic CH_PRESS = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_PUSH
    } dcqa_state_t;

    // Controller to datapath
    typedef struct packed {
        logic ch;          // channel being worked on
        logic load;        // capture the input transaction
        logic qualify;     // apply the range check and accumulate
        logic div_start;   // launch the shared divider
        logic clear_acc;   // clear sum and count of the channel
        logic push;        // load the output register
        logic push_fault;  // pushed result is a fault report
        logic push_last;   // pushed result is the last of this transaction
    } dcqa_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic full;         // selected channel holds a complete window
        logic fault_emit;   // qualifying the selected channel reports a fault
        logic press_emits;  // pressure channel will give a result
        logic div_done;     // divider quotient ready
        logic out_free;     // output register can take a result
    } dcqa_status_t;

endpackage

[hdl/dual_channel_qualified_averager_core.sv]
`timescale 1ns / 1ps
// ============================================================================
// dual_channel_qualified_averager_core
// Block averager with range check for a temperature and a pressure channel.
// ============================================================================
// Each input transaction carries one temperature and one pressure sample; the
// temperature channel is handled first, then the pressure channel, and each
// may give one result (an average or a fault report), the final one of the
// transaction marked by last. Items are taken one at a time: a new
// transaction is taken only once both channels of the last one are done,
// and a result waits to be pushed while the output register still holds an
// earlier result. An average is formed by the shared restoring divider,
// which produces one quotient bit per cycle over a dividend of
// SUM_W = SAMPLE_BITS + clog2(MAX_WINDOW) bits (22 at the defaults). The
// output register lets the next transaction in while a result waits to be
// taken. Configuration writes are always accepted and must be made while the
// block is idle.
// ============================================================================
module dual_channel_qualified_averager_core #(
    parameter int SAMPLE_BITS = 12,
    parameter int MAX_WINDOW  = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dcqa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dcqa_pkg::CODE_W-1:0]     cfg_data,
    // input channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [SAMPLE_BITS-1:0]          temp_sample,
    input  logic [SAMPLE_BITS-1:0]          press_sample,
    // output channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            channel,
    output logic                            is_fault,
    output logic [dcqa_pkg::VALUE_W-1:0]    value,
    output logic                            last
);

    dcqa_pkg::dcqa_cmd_t    cmd;
    dcqa_pkg::dcqa_status_t status;

    assign cfg_ready = 1'b1;

    dcqa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .status   (status)
    );

    dcqa_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_WINDOW  (MAX_WINDOW)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .temp_sample  (temp_sample),
        .press_sample (press_sample),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .channel      (channel),
        .is_fault     (is_fault),
        .value        (value),
        .last         (last),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

[hdl/dcqa_div.sv]
`timescale 1ns / 1ps
// ============================================================================
// dcqa_div
// Restoring divider shared by both channels, producing one quotient bit per cycle;
// only the low VALUE_W quotient bits are kept.
// ============================================================================
module dcqa_div #(
    parameter int DVD_W = 22,
    parameter int DVS_W = 11
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [DVD_W-1:0]              dividend,
    input  logic [DVS_W-1:0]              divisor,
    output logic                          done,
    output logic [dcqa_pkg::VALUE_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(DVD_W);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [DVD_W-1:0]             dvd_reg, dvd_next;
    logic [DVS_W-1:0]             dvs_reg, dvs_next;
    logic [DVS_W-1:0]             rem_reg, rem_next;
    logic [dcqa_pkg::VALUE_W-1:0] quo_reg, quo_next;

    logic [DVS_W:0] trial;
    logic [DVS_W:0] diff;
    logic           ge;

    // One restoring step
    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = dvd_reg << 1;
            rem_next = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_next = {quo_reg[dcqa_pkg::VALUE_W-2:0], ge};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operands and partial results
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[hdl/dcqa_datapath.sv]
`timescale 1ns / 1ps
// ============================================================================
// dcqa_datapath
// Configuration registers, per-channel accumulators, range check, shared
// divider and the output register.
// ============================================================================
module dcqa_datapath #(
    parameter int SAMPLE_BITS = 12,
    parameter int MAX_WINDOW  = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            cfg_valid,
    input  logic [dcqa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dcqa_pkg::CODE_W-1:0]     cfg_data,
    // input payload
    input  logic [SAMPLE_BITS-1:0]          temp_sample,
    input  logic [SAMPLE_BITS-1:0]          press_sample,
    // output channel
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic                            channel,
    output logic                            is_fault,
    output logic [dcqa_pkg::VALUE_W-1:0]    value,
    output logic                            last,
    // controller
    input  dcqa_pkg::dcqa_cmd_t             cmd,
    output dcqa_pkg::dcqa_status_t          status
);

    localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W = (SAMPLE_BITS > dcqa_pkg::LIMIT_W) ? SAMPLE_BITS : dcqa_pkg::LIMIT_W;

    // Configuration registers
    logic [dcqa_pkg::WIN_W-1:0]   window_length_reg;
    logic [dcqa_pkg::LIMIT_W-1:0] valid_low_reg;
    logic [dcqa_pkg::LIMIT_W-1:0] valid_high_reg;
    logic [dcqa_pkg::FLIM_W-1:0]  fault_limit_reg;
    logic [dcqa_pkg::CODE_W-1:0]  fault_code_reg;

    // Captured samples and channel state
    logic [SAMPLE_BITS-1:0]       temp_sample_reg, press_sample_reg;
    logic [SUM_W-1:0]             temp_sum_reg, press_sum_reg;
    logic [CNT_W-1:0]             temp_count_reg, press_count_reg;
    logic [dcqa_pkg::FLIM_W-1:0]  temp_faults_reg, press_faults_reg;

    // Output register
    logic                         out_valid_reg, out_valid_next;
    logic                         channel_reg, is_fault_reg, last_reg;
    logic [dcqa_pkg::VALUE_W-1:0] value_reg;

    logic [CNT_W-1:0]             eff_win;
    logic [SAMPLE_BITS-1:0]       sel_sample;
    logic [SUM_W-1:0]             sel_sum;
    logic [CNT_W-1:0]             sel_count;
    logic [dcqa_pkg::FLIM_W-1:0]  sel_faults;
    logic                         sel_faulty;
    logic [dcqa_pkg::FLIM_W-1:0]  sel_faults_inc;
    logic                         sel_emit;
    logic [SUM_W-1:0]             new_sum;
    logic [CNT_W-1:0]             new_count;
    logic [dcqa_pkg::FLIM_W-1:0]  new_faults;
    logic                         press_full, press_faulty;
    logic [dcqa_pkg::FLIM_W-1:0]  press_faults_inc;
    logic                         div_done;
    logic [dcqa_pkg::VALUE_W-1:0] quotient;

    // Window clamped to 1..MAX_WINDOW
    always_comb
    begin
        if (window_length_reg == '0)
            eff_win = CNT_W'(1);
        else if (32'(window_length_reg) > 32'(MAX_WINDOW))
            eff_win = CNT_W'(MAX_WINDOW);
        else
            eff_win = CNT_W'(window_length_reg);
    end

    // Selected channel
    assign sel_sample = (cmd.ch == dcqa_pkg::CH_PRESS) ? press_sample_reg : temp_sample_reg;
    assign sel_sum    = (cmd.ch == dcqa_pkg::CH_PRESS) ? press_sum_reg    : temp_sum_reg;
    assign sel_count  = (cmd.ch == dcqa_pkg::CH_PRESS) ? press_count_reg  : temp_count_reg;
    assign sel_faults = (cmd.ch == dcqa_pkg::CH_PRESS) ? press_faults_reg : temp_faults_reg;

    // Range check and accumulation of the selected channel
    assign sel_faulty = (CMP_W'(sel_sample) <= CMP_W'(valid_low_reg))
                     || (CMP_W'(sel_sample) >= CMP_W'(valid_high_reg));
    assign sel_faults_inc = sel_faulty ? (sel_faults + dcqa_pkg::FLIM_W'(1)) : '0;
    assign sel_emit   = sel_faults_inc >= fault_limit_reg;
    assign new_sum    = sel_faulty ? '0 : (sel_sum + SUM_W'(sel_sample));
    assign new_count  = sel_faulty ? '0 : (sel_count + CNT_W'(1));
    assign new_faults = sel_emit ? '0 : sel_faults_inc;

    // Look-ahead on the pressure channel, for the last flag of a temperature result
    assign press_full   = press_count_reg >= eff_win;
    assign press_faulty = (CMP_W'(press_sample_reg) <= CMP_W'(valid_low_reg))
                       || (CMP_W'(press_sample_reg) >= CMP_W'(valid_high_reg));
    assign press_faults_inc = press_faulty ? (press_faults_reg + dcqa_pkg::FLIM_W'(1)) : '0;

    always_comb
    begin
        status.full        = sel_count >= eff_win;
        status.fault_emit  = sel_emit;
        status.press_emits = press_full || (press_faults_inc >= fault_limit_reg);
        status.div_done    = div_done;
        status.out_free    = !out_valid_reg || out_ready;
    end

    // Shared divider
    dcqa_div #(
        .DVD_W (SUM_W),
        .DVS_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sel_sum),
        .divisor  (sel_count),
        .done     (div_done),
        .quotient (quotient)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= dcqa_pkg::RST_WINDOW_LENGTH;
            valid_low_reg     <= dcqa_pkg::RST_VALID_LOW;
            valid_high_reg    <= dcqa_pkg::RST_VALID_HIGH;
            fault_limit_reg   <= dcqa_pkg::RST_FAULT_LIMIT;
            fault_code_reg    <= dcqa_pkg::RST_FAULT_CODE;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                dcqa_pkg::CFG_WINDOW_LENGTH: window_length_reg <= cfg_data[dcqa_pkg::WIN_W-1:0];
                dcqa_pkg::CFG_VALID_LOW:     valid_low_reg     <= cfg_data[dcqa_pkg::LIMIT_W-1:0];
                dcqa_pkg::CFG_VALID_HIGH:    valid_high_reg    <= cfg_data[dcqa_pkg::LIMIT_W-1:0];
                dcqa_pkg::CFG_FAULT_LIMIT:   fault_limit_reg   <= cfg_data[dcqa_pkg::FLIM_W-1:0];
                dcqa_pkg::CFG_FAULT_CODE:    fault_code_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            temp_sample_reg  <= temp_sample;
            press_sample_reg <= press_sample;
        end
    end

    // Channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_sum_reg     <= '0;
            temp_count_reg   <= '0;
            temp_faults_reg  <= '0;
            press_sum_reg    <= '0;
            press_count_reg  <= '0;
            press_faults_reg <= '0;
        end
        else if (cmd.qualify)
        begin
            if (cmd.ch == dcqa_pkg::CH_PRESS)
            begin
                press_sum_reg    <= new_sum;
                press_count_reg  <= new_count;
                press_faults_reg <= new_faults;
            end
            else
            begin
                temp_sum_reg    <= new_sum;
                temp_count_reg  <= new_count;
                temp_faults_reg <= new_faults;
            end
        end
        else if (cmd.clear_acc)
        begin
            if (cmd.ch == dcqa_pkg::CH_PRESS)
            begin
                press_sum_reg   <= '0;
                press_count_reg <= '0;
            end
            else
            begin
                temp_sum_reg   <= '0;
                temp_count_reg <= '0;
            end
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.push)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            channel_reg  <= cmd.ch;
            is_fault_reg <= cmd.push_fault;
            value_reg    <= cmd.push_fault ? fault_code_reg : quotient;
            last_reg     <= cmd.push_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign channel   = channel_reg;
    assign is_fault  = is_fault_reg;
    assign value     = value_reg;
    assign last      = last_reg;

endmodule

[hdl/dcqa_ctrl.sv]
`timescale 1ns / 1ps
// ============================================================================
// dcqa_ctrl
// Controller: takes one input transaction, then walks the temperature and the
// pressure channel in turn, launching the divider and pushing results.
// ============================================================================
module dcqa_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    output dcqa_pkg::dcqa_cmd_t     cmd,
    input  dcqa_pkg::dcqa_status_t  status
);

    dcqa_pkg::dcqa_state_t state_reg, state_next;
    logic                  ch_reg, ch_next;
    logic                  fault_reg, fault_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        fault_next = fault_reg;
        case (state_reg)
            dcqa_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = dcqa_pkg::ST_EVAL;
                    ch_next    = dcqa_pkg::CH_TEMP;
                end
            end
            dcqa_pkg::ST_EVAL:
            begin
                fault_next = !status.full;
                if (status.full)
                    state_next = dcqa_pkg::ST_DIV;
                else if (status.fault_emit)
                    state_next = dcqa_pkg::ST_PUSH;
                else if (ch_reg == dcqa_pkg::CH_TEMP)
                    ch_next = dcqa_pkg::CH_PRESS;
                else
                    state_next = dcqa_pkg::ST_IDLE;
            end
            dcqa_pkg::ST_DIV:
            begin
                if (status.div_done)
                    state_next = dcqa_pkg::ST_PUSH;
            end
            dcqa_pkg::ST_PUSH:
            begin
                if (status.out_free)
                begin
                    if (ch_reg == dcqa_pkg::CH_TEMP)
                    begin
                        state_next = dcqa_pkg::ST_EVAL;
                        ch_next    = dcqa_pkg::CH_PRESS;
                    end
                    else
                        state_next = dcqa_pkg::ST_IDLE;
                end
            end
            default: state_next = dcqa_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.ch         = ch_reg;
        cmd.push_fault = fault_reg;
        cmd.push_last  = (ch_reg == dcqa_pkg::CH_PRESS) || !status.press_emits;
        case (state_reg)
            dcqa_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            dcqa_pkg::ST_EVAL:
            begin
                cmd.div_start = status.full;
                cmd.qualify   = !status.full;
            end
            dcqa_pkg::ST_DIV:  cmd.clear_acc = status.div_done;
            dcqa_pkg::ST_PUSH: cmd.push      = status.out_free;
            default: ;
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dcqa_pkg::ST_IDLE;
            ch_reg    <= dcqa_pkg::CH_TEMP;
            fault_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            fault_reg <= fault_next;
        end
    end

endmodule

[hdl/dcqa_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// dcqa_checker
// Port-level checks on the averager, bound to the top level.
// ============================================================================
module dcqa_checker #(
    parameter int SAMPLE_BITS = 12
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          channel,
    input logic                          is_fault,
    input logic [dcqa_pkg::VALUE_W-1:0]  value,
    input logic                          last
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value) && $stable(is_fault)
            && $stable(channel) && $stable(last))
        else $error("stalled result changed or dropped");

    // The block is busy in the cycle after taking a transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken twice in a row");

    // A new result is only produced while a transaction is in progress
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared while idle");

    // An average never exceeds the largest value a SAMPLE_BITS-wide sample can hold
    a_avg_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_fault |-> (32'(value) >> SAMPLE_BITS) == 32'd0)
        else $error("average out of sample range");

endmodule

bind dual_channel_qualified_averager_core dcqa_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_dcqa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .channel   (channel),
    .is_fault  (is_fault),
    .value     (value),
    .last      (last)
);
